>>> hw/rtl/tmht_pkg.sv
// Shared constants, types and helpers for the triangle mesh hit test unit.
// Used by tmht_edge_unit and triangle_mesh_hit_test_unit.
package tmht_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int MAX_INDICES = 48;
  localparam int COORD_BITS  = 16;
  localparam int IN_BITS     = 16;
  localparam int PI_BITS     = 8;
  localparam int TRI_SIZE    = 3;

  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int PCNT_W = $clog2(MAX_POINTS + 1);
  localparam int SLOT_W = $clog2(MAX_INDICES);
  localparam int ICNT_W = $clog2(MAX_INDICES + 1);
  localparam int CMP_W  = (PI_BITS > PCNT_W) ? PI_BITS : PCNT_W;

  // Room for coordinate plus offset without overflow.
  localparam int WIDE_W = ((COORD_BITS > IN_BITS) ? COORD_BITS : IN_BITS) + 2;
  localparam int DIFF_W = WIDE_W - 1;
  localparam int PROD_W = 2 * DIFF_W;

  localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN = -CMAX - 1;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_APPEND_PT  = 3'd1,
    OP_APPEND_IDX = 3'd2,
    OP_MOVE       = 3'd3,
    OP_TEST       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_TRI = 2'd1,
    ST_DROP   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MV_BASE, S_MV_RUN,
    S_HT_I0, S_HT_I1, S_HT_I2, S_HT_P0, S_HT_P1, S_HT_P2,
    S_HT_E0, S_HT_E1, S_HT_E2, S_HT_E3, S_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] r;
    hi = WIDE_W'(CMAX);
    lo = WIDE_W'(CMIN);
    r  = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return r[COORD_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/triangle_mesh_hit_test_unit.sv
// Triangle mesh hit test unit: point and index memories with a sequencer.
// Depends on tmht_pkg and tmht_edge_unit.
//
// Usage:
//   Input requests (in_valid/in_stall) carry op, x, y and point index. Each
//   request yields exactly one result (out_valid/out_stall) with hit and
//   status. One request is worked on at a time; in_stall is high while it
//   runs. A finished result sits in the output register, and the next
//   request is taken from the cycle after it loads there.
// Request handling:
//   clear, append point, append index, unused codes, and move or test with
//   no whole triangle: done in S_EXEC, then the result waits in S_DONE.
//   move: reads point 0 for the offset, then one point read-modify-write per
//   cycle through the single point memory port.
//   hit test: for each triangle walked, the index reads go through the single
//   index memory port and the point reads through the single point memory
//   port, then the edge unit tests each edge. The walk stops at the first hit.
// Reset (synchronous, rst_n low) empties the mesh and the output register;
// memory contents are not cleared and need no clearing pass.
// While out_stall is high a valid result holds and a finished request waits.
module triangle_mesh_hit_test_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_op,
  input  logic signed [tmht_pkg::IN_BITS-1:0] in_x_coord,
  input  logic signed [tmht_pkg::IN_BITS-1:0] in_y_coord,
  input  logic [tmht_pkg::PI_BITS-1:0]        in_point_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [1:0]                          out_status
);
  import tmht_pkg::*;

  state_t state_r, state_nxt;
  logic [PCNT_W-1:0] pcount_r, pcount_nxt;
  logic [ICNT_W-1:0] icount_r, icount_nxt;
  logic [2:0]        op_r;
  logic signed [IN_BITS-1:0] x_r, y_r;
  logic [PI_BITS-1:0] pi_r;
  logic signed [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [PIDX_W-1:0] idx_r, idx_nxt;
  logic [ICNT_W-1:0] slot_r, slot_nxt;
  logic [PIDX_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt, ic_r, ic_nxt;
  point_t va_r, va_nxt, vb_r, vb_nxt, vc_r, vc_nxt;
  logic e0_r, e0_nxt, e1_r, e1_nxt;
  logic res_hit_r, res_hit_nxt;
  status_t res_status_r, res_status_nxt;
  logic out_valid_r, out_hit_r;
  status_t out_status_r;
  logic out_load;

  // Point memory
  point_t pmem [MAX_POINTS];
  logic pm_we;
  logic [PIDX_W-1:0] pm_waddr, pm_raddr;
  point_t pm_wdata, pm_rdata_r;

  // Index memory
  logic [PIDX_W-1:0] imem [MAX_INDICES];
  logic im_we;
  logic [SLOT_W-1:0] im_waddr, im_raddr;
  logic [PIDX_W-1:0] im_wdata, im_rdata_r;

  // Edge unit
  point_t ea, eb;
  logic epos;

  logic accept;
  logic [PCNT_W-1:0] nidx;
  logic [ICNT_W:0]   slot_end;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_waddr] <= pm_wdata;
    end
    pm_rdata_r <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (im_we) begin
      imem[im_waddr] <= im_wdata;
    end
    im_rdata_r <= imem[im_raddr];
  end

  tmht_edge_unit u_edge (
    .clk (clk),
    .pa  (ea),
    .pb  (eb),
    .qx  (x_r),
    .qy  (y_r),
    .pos (epos)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign nidx     = PCNT_W'(idx_r) + PCNT_W'(1);
  assign slot_end = (ICNT_W+1)'(slot_r) + (ICNT_W+1)'(TRI_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcount_r    <= '0;
      icount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pcount_r <= pcount_nxt;
      icount_r <= icount_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      x_r  <= in_x_coord;
      y_r  <= in_y_coord;
      pi_r <= in_point_index;
    end
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    idx_r        <= idx_nxt;
    slot_r       <= slot_nxt;
    ia_r         <= ia_nxt;
    ib_r         <= ib_nxt;
    ic_r         <= ic_nxt;
    va_r         <= va_nxt;
    vb_r         <= vb_nxt;
    vc_r         <= vc_nxt;
    e0_r         <= e0_nxt;
    e1_r         <= e1_nxt;
    res_hit_r    <= res_hit_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_hit_r    <= res_hit_r;
      out_status_r <= res_status_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pcount_nxt     = pcount_r;
    icount_nxt     = icount_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    idx_nxt        = idx_r;
    slot_nxt       = slot_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    ic_nxt         = ic_r;
    va_nxt         = va_r;
    vb_nxt         = vb_r;
    vc_nxt         = vc_r;
    e0_nxt         = e0_r;
    e1_nxt         = e1_r;
    res_hit_nxt    = res_hit_r;
    res_status_nxt = res_status_r;
    pm_we          = 1'b0;
    pm_waddr       = pcount_r[PIDX_W-1:0];
    pm_wdata.x     = sat_coord(WIDE_W'(x_r));
    pm_wdata.y     = sat_coord(WIDE_W'(y_r));
    pm_raddr       = '0;
    im_we          = 1'b0;
    im_waddr       = icount_r[SLOT_W-1:0];
    im_wdata       = pi_r[PIDX_W-1:0];
    im_raddr       = slot_r[SLOT_W-1:0];
    ea             = va_r;
    eb             = vb_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_hit_nxt    = 1'b0;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
        unique case (op_r)
          OP_CLEAR: begin
            pcount_nxt = '0;
            icount_nxt = '0;
          end
          OP_APPEND_PT: begin
            if (pcount_r < PCNT_W'(MAX_POINTS)) begin
              pm_we      = 1'b1;
              pcount_nxt = pcount_r + PCNT_W'(1);
            end else begin
              res_status_nxt = ST_DROP;
            end
          end
          OP_APPEND_IDX: begin
            if (CMP_W'(pi_r) < CMP_W'(pcount_r) &&
                icount_r < ICNT_W'(MAX_INDICES)) begin
              im_we      = 1'b1;
              icount_nxt = icount_r + ICNT_W'(1);
            end else begin
              res_status_nxt = ST_DROP;
            end
          end
          OP_MOVE: begin
            if (icount_r < ICNT_W'(TRI_SIZE)) begin
              res_status_nxt = ST_NO_TRI;
            end else begin
              pm_raddr  = '0;
              state_nxt = S_MV_BASE;
            end
          end
          OP_TEST: begin
            if (icount_r < ICNT_W'(TRI_SIZE)) begin
              res_status_nxt = ST_NO_TRI;
            end else begin
              slot_nxt  = '0;
              state_nxt = S_HT_I0;
            end
          end
          default: begin
          end
        endcase
      end

      S_MV_BASE: begin
        // offset taken from point 0 as stored
        dx_nxt    = DIFF_W'(x_r) - DIFF_W'(pm_rdata_r.x);
        dy_nxt    = DIFF_W'(y_r) - DIFF_W'(pm_rdata_r.y);
        pm_raddr  = '0;
        idx_nxt   = '0;
        state_nxt = S_MV_RUN;
      end

      S_MV_RUN: begin
        // write back the point read last cycle, fetch the next one
        pm_we      = 1'b1;
        pm_waddr   = idx_r;
        pm_wdata.x = sat_coord(WIDE_W'(pm_rdata_r.x) + WIDE_W'(dx_r));
        pm_wdata.y = sat_coord(WIDE_W'(pm_rdata_r.y) + WIDE_W'(dy_r));
        if (nidx < pcount_r) begin
          pm_raddr = nidx[PIDX_W-1:0];
          idx_nxt  = nidx[PIDX_W-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_HT_I0: begin
        slot_nxt  = slot_r + ICNT_W'(1);
        state_nxt = S_HT_I1;
      end

      S_HT_I1: begin
        ia_nxt    = im_rdata_r;
        slot_nxt  = slot_r + ICNT_W'(1);
        state_nxt = S_HT_I2;
      end

      S_HT_I2: begin
        ib_nxt    = im_rdata_r;
        slot_nxt  = slot_r + ICNT_W'(1);
        state_nxt = S_HT_P0;
      end

      S_HT_P0: begin
        ic_nxt    = im_rdata_r;
        pm_raddr  = ia_r;
        state_nxt = S_HT_P1;
      end

      S_HT_P1: begin
        va_nxt    = pm_rdata_r;
        pm_raddr  = ib_r;
        state_nxt = S_HT_P2;
      end

      S_HT_P2: begin
        vb_nxt    = pm_rdata_r;
        pm_raddr  = ic_r;
        state_nxt = S_HT_E0;
      end

      S_HT_E0: begin
        vc_nxt    = pm_rdata_r;
        ea        = va_r;
        eb        = vb_r;
        state_nxt = S_HT_E1;
      end

      S_HT_E1: begin
        ea        = vb_r;
        eb        = vc_r;
        e0_nxt    = epos;
        state_nxt = S_HT_E2;
      end

      S_HT_E2: begin
        ea        = vc_r;
        eb        = va_r;
        e1_nxt    = epos;
        state_nxt = S_HT_E3;
      end

      S_HT_E3: begin
        if (e0_r == e1_r && e1_r == epos) begin
          res_hit_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else if (slot_end <= (ICNT_W+1)'(icount_r)) begin
          // next whole triangle
          state_nxt = S_HT_I0;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_status = out_status_r;

endmodule

>>> hw/rtl/tmht_edge_unit.sv
// Edge-function unit: registers the two product terms of the cross product of one edge and query.
// Depends on tmht_pkg.
module tmht_edge_unit (
  input  logic                                clk,
  input  tmht_pkg::point_t                    pa,
  input  tmht_pkg::point_t                    pb,
  input  logic signed [tmht_pkg::IN_BITS-1:0] qx,
  input  logic signed [tmht_pkg::IN_BITS-1:0] qy,
  output logic                                pos
);
  import tmht_pkg::*;

  logic signed [DIFF_W-1:0] d1, d2, d3, d4;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [PROD_W-1:0] p1_r, p2_r;

  assign d1 = DIFF_W'(pa.x) - DIFF_W'(qx);
  assign d2 = DIFF_W'(pb.y) - DIFF_W'(pa.y);
  assign d3 = DIFF_W'(pb.x) - DIFF_W'(pa.x);
  assign d4 = DIFF_W'(pa.y) - DIFF_W'(qy);
  assign p1 = d1 * d2;
  assign p2 = d3 * d4;

  always_ff @(posedge clk) begin
    p1_r <= p1;
    p2_r <= p2;
  end

  // Cross product strictly positive.
  assign pos = p1_r > p2_r;

endmodule

>>> tb/tb_triangle_mesh_hit_test_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for triangle_mesh_hit_test_unit: directed table, then random meshes.
// Depends on tmht_pkg and the unit's RTL; a local mesh model predicts the replies the table does not give.
module tb_triangle_mesh_hit_test_unit;
  import tmht_pkg::*;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int ITEM_TARGET  = 1950;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic       hit;
    logic [1:0] status;
  } reply_t;

  typedef struct {
    logic [2:0] op;
    int         x;
    int         y;
    int         pidx;
    bit         typed;
    reply_t     reply;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [2:0]                in_op = '0;
  logic signed [IN_BITS-1:0] in_x_coord = '0;
  logic signed [IN_BITS-1:0] in_y_coord = '0;
  logic [PI_BITS-1:0]        in_point_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_hit;
  logic [1:0]                out_status;

  // local copy of the mesh
  logic signed [COORD_BITS-1:0] mesh_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mesh_y [MAX_POINTS];
  logic [PIDX_W-1:0]            mesh_idx [MAX_INDICES];
  int                           mesh_points = 0;
  int                           mesh_indices = 0;

  reply_t   replies_due [$];
  dir_row_t dir_rows [$];
  reply_t   oldest_due;

  int send_idle_pct = 18;
  int recv_stall_pct = 59;
  int load_phase = 0;
  bit hold_request = 1'b0;
  int holds_done = 0;
  int items_sent = 0;
  int replies_checked = 0;
  int hits_seen = 0;
  int drops_seen = 0;
  int no_tri_seen = 0;
  int errors = 0;
  int quiet_cycles = 0;

  triangle_mesh_hit_test_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_point_index(in_point_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_status    (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [COORD_BITS-1:0] clamp_pixel(input longint v);
    if (v > CMAX) return COORD_BITS'(CMAX);
    if (v < CMIN) return COORD_BITS'(CMIN);
    return COORD_BITS'(v);
  endfunction

  function automatic bit edge_positive(input int a, input int b, input longint qx,
                                       input longint qy);
    longint ax, ay, bx, by;
    ax = mesh_x[a];
    ay = mesh_y[a];
    bx = mesh_x[b];
    by = mesh_y[b];
    return (ax - qx) * (by - ay) - (bx - ax) * (ay - qy) > 0;
  endfunction

  // Apply one request to the local mesh and return the reply it should produce.
  function automatic reply_t predict_mesh_reply(input logic [2:0] op,
                                                input logic signed [IN_BITS-1:0] x,
                                                input logic signed [IN_BITS-1:0] y,
                                                input logic [PI_BITS-1:0] pidx);
    reply_t r;
    longint qx, qy, dx, dy;
    int tris, a, b, c;
    bit e1, e2, e3;
    r.hit = 1'b0;
    r.status = ST_OK;
    qx = x;
    qy = y;
    tris = mesh_indices / TRI_SIZE;
    case (op)
      OP_CLEAR: begin
        mesh_points = 0;
        mesh_indices = 0;
      end
      OP_APPEND_PT: begin
        if (mesh_points < MAX_POINTS) begin
          mesh_x[mesh_points] = clamp_pixel(qx);
          mesh_y[mesh_points] = clamp_pixel(qy);
          mesh_points++;
        end else begin
          r.status = ST_DROP;
        end
      end
      OP_APPEND_IDX: begin
        if (pidx < mesh_points && mesh_indices < MAX_INDICES) begin
          mesh_idx[mesh_indices] = pidx[PIDX_W-1:0];
          mesh_indices++;
        end else begin
          r.status = ST_DROP;
        end
      end
      OP_MOVE: begin
        if (tris == 0) begin
          r.status = ST_NO_TRI;
        end else begin
          // offset comes from point 0 before any point moves
          dx = qx - mesh_x[0];
          dy = qy - mesh_y[0];
          for (int i = 0; i < mesh_points; i++) begin
            mesh_x[i] = clamp_pixel(mesh_x[i] + dx);
            mesh_y[i] = clamp_pixel(mesh_y[i] + dy);
          end
        end
      end
      OP_TEST: begin
        if (tris == 0) begin
          r.status = ST_NO_TRI;
        end else begin
          for (int t = 0; t < tris && !r.hit; t++) begin
            a = mesh_idx[TRI_SIZE * t];
            b = mesh_idx[TRI_SIZE * t + 1];
            c = mesh_idx[TRI_SIZE * t + 2];
            e1 = edge_positive(a, b, qx, qy);
            e2 = edge_positive(b, c, qx, qy);
            e3 = edge_positive(c, a, qx, qy);
            if (e1 == e2 && e2 == e3) r.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int rand16();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pixel_near(input int center, input int spread);
    int off, v;
    off = $urandom_range(2 * spread);
    v = center + off - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int index_pick();
    if ($urandom_range(19) == 0 || mesh_points == 0) return $urandom_range(255);
    return $urandom_range(mesh_points - 1);
  endfunction

  // Drive one request from the falling edge and hold it until accepted.
  task automatic offer(input logic [2:0] op, input logic signed [IN_BITS-1:0] x,
                       input logic signed [IN_BITS-1:0] y, input logic [PI_BITS-1:0] pidx);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_x_coord     <= x;
    in_y_coord     <= y;
    in_point_index <= pidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op <= OP_TEST) items_sent++;
    if (load_phase == 0 && items_sent >= ITEM_TARGET / 3) begin
      load_phase = 1;
      send_idle_pct = 59;
      recv_stall_pct = 18;
    end else if (load_phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
      load_phase = 2;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
    end
  endtask

  task automatic issue(input logic [2:0] op, input int x, input int y, input int pidx);
    reply_t r;
    offer(op, x[15:0], y[15:0], pidx[7:0]);
    r = predict_mesh_reply(op, x[15:0], y[15:0], pidx[7:0]);
    replies_due.insert(replies_due.size(), r);
  endtask

  task automatic add_row(input logic [2:0] op, input int x, input int y, input int pidx,
                         input bit typed, input logic hit, input logic [1:0] status);
    dir_row_t row;
    row.op = op;
    row.x = x;
    row.y = y;
    row.pidx = pidx;
    row.typed = typed;
    row.reply.hit = hit;
    row.reply.status = status;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // One mesh: usually a clear, then points, indices, then a burst of moves, tests and noise.
  task automatic run_mesh_session();
    int cx, cy, spread, n_pts, n_tris, n_extra, n_probe, v, t, jit;
    longint sx, sy;
    cx = rand16();
    cy = rand16();
    spread = ($urandom_range(99) < 70) ? $urandom_range(400, 8) : 40000;
    if ($urandom_range(9) != 0) issue(OP_CLEAR, rand16(), rand16(), $urandom_range(255));
    v = $urandom_range(99);
    n_pts = (v < 80) ? $urandom_range(8, 3) : (v < 95) ? $urandom_range(16, 9)
                                                        : $urandom_range(19, 17);
    repeat (n_pts) issue(OP_APPEND_PT, pixel_near(cx, spread), pixel_near(cy, spread),
                         $urandom_range(255));
    v = $urandom_range(99);
    n_tris = (v < 5) ? 0 : (v < 80) ? $urandom_range(4, 1) : (v < 95) ? $urandom_range(16, 5)
                                                                       : 17;
    n_extra = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
    repeat (TRI_SIZE * n_tris + n_extra) issue(OP_APPEND_IDX, rand16(), rand16(), index_pick());
    n_probe = $urandom_range(12, 3);
    repeat (n_probe) begin
      v = $urandom_range(99);
      if (v < 70) begin
        // aim at the centroid of some triangle, with a small or large miss
        if (mesh_indices >= TRI_SIZE) begin
          t = $urandom_range(mesh_indices / TRI_SIZE - 1);
          sx = 0;
          sy = 0;
          for (int k = 0; k < TRI_SIZE; k++) begin
            sx += mesh_x[mesh_idx[TRI_SIZE * t + k]];
            sy += mesh_y[mesh_idx[TRI_SIZE * t + k]];
          end
          jit = ($urandom_range(3) == 0) ? spread : 3;
          issue(OP_TEST, pixel_near(int'(sx / 3), jit), pixel_near(int'(sy / 3), jit),
                $urandom_range(255));
        end else begin
          issue(OP_TEST, pixel_near(cx, spread), pixel_near(cy, spread), $urandom_range(255));
        end
      end else if (v < 82) begin
        issue(OP_MOVE, pixel_near(cx, spread), pixel_near(cy, spread), $urandom_range(255));
      end else if (v < 88) begin
        issue(OP_APPEND_PT, pixel_near(cx, spread), pixel_near(cy, spread),
              $urandom_range(255));
      end else if (v < 94) begin
        issue(OP_APPEND_IDX, rand16(), rand16(), index_pick());
      end else if (v < 97) begin
        issue(OP_TEST, rand16(), rand16(), $urandom_range(255));
      end else begin
        issue(3'($urandom_range(OP_SPARE_7, OP_SPARE_5)), rand16(), rand16(),
              $urandom_range(255));
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (out_hit) hits_seen++;
      if (out_status == ST_DROP) drops_seen++;
      if (out_status == ST_NO_TRI) no_tri_seen++;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result hit=%0d status=%0d", $time, out_hit, out_status);
      end else begin
        oldest_due = replies_due.pop_front();
        replies_checked++;
        if (out_hit !== oldest_due.hit) begin
          errors++;
          $display("%0t: hit mismatch, expected %0d, got %0d", $time, oldest_due.hit, out_hit);
        end
        if (out_status !== oldest_due.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d", $time, oldest_due.status,
                   out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(OP_TEST,        0,      0,      0,   1, 1'b0, ST_NO_TRI);
    add_row(OP_MOVE,        100,    -100,   0,   1, 1'b0, ST_NO_TRI);
    add_row(OP_APPEND_IDX,  0,      0,      0,   1, 1'b0, ST_DROP);
    add_row(OP_SPARE_5,     -1,     -1,     255, 1, 1'b0, ST_OK);
    add_row(OP_SPARE_7,     32767,  -32768, 170, 1, 1'b0, ST_OK);
    add_row(OP_APPEND_PT,   -32768, -32768, 0,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_PT,   32767,  -32768, 0,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_PT,   -32768, 32767,  0,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_PT,   0,      0,      0,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_IDX,  0,      0,      0,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_IDX,  0,      0,      1,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_IDX,  0,      0,      2,   1, 1'b0, ST_OK);
    // one trailing index: a partial triangle
    add_row(OP_APPEND_IDX,  0,      0,      3,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_IDX,  0,      0,      255, 1, 1'b0, ST_DROP);
    add_row(OP_TEST,        -100,   -100,   0,   0, 1'b0, ST_OK);
    add_row(OP_TEST,        32767,  32767,  0,   0, 1'b0, ST_OK);
    add_row(OP_TEST,        -32768, -32768, 0,   0, 1'b0, ST_OK);
    // moves that push every point into saturation
    add_row(OP_MOVE,        32767,  32767,  0,   0, 1'b0, ST_OK);
    add_row(OP_TEST,        32767,  32767,  0,   0, 1'b0, ST_OK);
    add_row(OP_MOVE,        -32768, -32768, 0,   0, 1'b0, ST_OK);
    // complete a collapsed triangle: every edge value is zero
    add_row(OP_APPEND_IDX,  0,      0,      3,   1, 1'b0, ST_OK);
    add_row(OP_APPEND_IDX,  0,      0,      3,   1, 1'b0, ST_OK);
    add_row(OP_TEST,        12345,  -4321,  0,   0, 1'b0, ST_OK);
    add_row(OP_CLEAR,       0,      0,      0,   1, 1'b0, ST_OK);
    add_row(OP_TEST,        0,      0,      0,   1, 1'b0, ST_NO_TRI);

    foreach (dir_rows[k]) begin
      issue(dir_rows[k].op, dir_rows[k].x, dir_rows[k].y, dir_rows[k].pidx);
      if (dir_rows[k].typed) replies_due[replies_due.size() - 1] = dir_rows[k].reply;
    end

    while (items_sent < ITEM_TARGET) run_mesh_session();
    @(negedge clk);
    in_valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d results (%0d hits, %0d drops, %0d no-triangle).",
             items_sent, replies_checked, hits_seen, drops_seen, no_tri_seen);
    $display("Ran three idle/stall mixes and %0d long result-side hold-off(s).", holds_done);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
